FILE: rtl/lmts_pkg.sv
// Package for the LED matrix text scan controller.
// Holds the command codes, sequencer states, control struct and the 5x7 font ROM.
// Has no dependencies.
`default_nettype none

package lmts_pkg;

    localparam int DEF_ROWS      = 7;
    localparam int DEF_COLUMNS   = 50;
    localparam int DEF_ROW_BYTES = 7;

    localparam int PATTERN_W = 56;
    localparam int SCAN_W    = 3;
    localparam int CMD_W     = 3;

    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PIXEL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GLYPH   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALL_OFF = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ALL_ON  = 3'd4;

    localparam logic [2:0] GLYPH_STEPS = 3'd5;
    localparam logic [2:0] PIXEL_STEPS = 3'd1;
    localparam logic [6:0] MASK_GLYPH  = 7'h7F;
    localparam logic [6:0] MASK_PIXEL  = 7'h40;

    typedef enum logic {
        ST_IDLE,
        ST_DRAW
    } t_state;

    typedef struct packed {
        logic              fill_en;
        logic              fill_val;
        logic              col_en;
        logic signed [7:0] col;
        logic signed [3:0] row;
        logic [6:0]        bits;
        logic [6:0]        mask;
        logic              inv;
    } t_frame_ctl;

    // Five font columns, leftmost in bits 39..32; bit 6 of a column is the top row.
    function automatic logic [39:0] f_glyph(input logic [7:0] code);
        logic [39:0] g;
        unique case (code)
            8'd32:  g = 40'h0000000000;
            8'd33:  g = 40'h00007D0000;
            8'd34:  g = 40'h0070007000;
            8'd35:  g = 40'h143E143E14;
            8'd36:  g = 40'h102A7F2A04;
            8'd37:  g = 40'h6264081323;
            8'd38:  g = 40'h3649552205;
            8'd39:  g = 40'h0050600000;
            8'd40:  g = 40'h1C22414100;
            8'd41:  g = 40'h004141221C;
            8'd42:  g = 40'h2A1CFF1C2A;
            8'd43:  g = 40'h08083E0808;
            8'd44:  g = 40'h0005060000;
            8'd45:  g = 40'h0808080808;
            8'd46:  g = 40'h0003030000;
            8'd47:  g = 40'h0204081020;
            8'd48:  g = 40'h3E4549513E;
            8'd49:  g = 40'h11217F0101;
            8'd50:  g = 40'h2143454931;
            8'd51:  g = 40'h4241515966;
            8'd52:  g = 40'h0C1424FF04;
            8'd53:  g = 40'h725151514E;
            8'd54:  g = 40'h3E49494926;
            8'd55:  g = 40'h4344485060;
            8'd56:  g = 40'h3649494936;
            8'd57:  g = 40'h324949493E;
            8'd58:  g = 40'h0036000000;
            8'd59:  g = 40'h0035360000;
            8'd60:  g = 40'h0814224100;
            8'd61:  g = 40'h1414141414;
            8'd62:  g = 40'h0041221408;
            8'd63:  g = 40'h20404D5030;
            8'd64:  g = 40'h3E4955493A;
            8'd65:  g = 40'h1F2444241F;
            8'd66:  g = 40'h7F49494936;
            8'd67:  g = 40'h3E41414120;
            8'd68:  g = 40'h7F4141221C;
            8'd69:  g = 40'h7F49494941;
            8'd70:  g = 40'h7F48484840;
            8'd71:  g = 40'h3E4149492E;
            8'd72:  g = 40'h7F0808087F;
            8'd73:  g = 40'h4141FF4141;
            8'd74:  g = 40'h0641417E40;
            8'd75:  g = 40'h7F08142241;
            8'd76:  g = 40'h7F01010101;
            8'd77:  g = 40'h7F2010207F;
            8'd78:  g = 40'h7F1008047F;
            8'd79:  g = 40'h3E4141413E;
            8'd80:  g = 40'h7F48484830;
            8'd81:  g = 40'h3E4145423D;
            8'd82:  g = 40'h7F48484837;
            8'd83:  g = 40'h3249494926;
            8'd84:  g = 40'h40407F4040;
            8'd85:  g = 40'h7E0101017E;
            8'd86:  g = 40'h7C0201027E;
            8'd87:  g = 40'h7E010E017E;
            8'd88:  g = 40'h6314081463;
            8'd89:  g = 40'h7008070870;
            8'd90:  g = 40'h4345495161;
            8'd91:  g = 40'h007F414100;
            8'd92:  g = 40'h2010080402;
            8'd93:  g = 40'h0041417F00;
            8'd94:  g = 40'h1020402010;
            8'd95:  g = 40'h0101010101;
            8'd96:  g = 40'h0040201000;
            8'd97:  g = 40'h021515150F;
            8'd98:  g = 40'h7F1111110E;
            8'd99:  g = 40'h0E11111102;
            8'd100: g = 40'h0E1111097F;
            8'd101: g = 40'h0E1515150C;
            8'd102: g = 40'h00083F4820;
            8'd103: g = 40'h0C1515151E;
            8'd104: g = 40'h7F0810100F;
            8'd105: g = 40'h00115F0100;
            8'd106: g = 40'h0201012E00;
            8'd107: g = 40'h7F040C1201;
            8'd108: g = 40'h00407F0000;
            8'd109: g = 40'h0F100C100F;
            8'd110: g = 40'h1F0810100F;
            8'd111: g = 40'h0E1111110E;
            8'd112: g = 40'h3F14242418;
            8'd113: g = 40'h182424283F;
            8'd114: g = 40'h1F08101008;
            8'd115: g = 40'h0915151502;
            8'd116: g = 40'h107E110102;
            8'd117: g = 40'h1E0101021F;
            8'd118: g = 40'h1C0201021C;
            8'd119: g = 40'h1E0106011E;
            8'd120: g = 40'h110A040A11;
            8'd121: g = 40'h180505051E;
            8'd122: g = 40'h1113151911;
            8'd123: g = 40'h0008364100;
            8'd124: g = 40'h00007F0000;
            8'd125: g = 40'h0041360800;
            8'd126: g = 40'h0408040204;
            8'd249: g = 40'h1E2151221F;
            8'd232: g = 40'h0E51315102;
            8'd239: g = 40'h4E2949067F;
            8'd236: g = 40'h0E5535550C;
            8'd242: g = 40'h1F4830500F;
            8'd248: g = 40'h1F48305008;
            8'd154: g = 40'h0955355502;
            8'd157: g = 40'h107E115162;
            8'd158: g = 40'h1153355911;
            8'd225: g = 40'h021535550F;
            8'd233: g = 40'h0E1535550C;
            8'd237: g = 40'h00092F4100;
            8'd243: g = 40'h0E1131510E;
            8'd250: g = 40'h1E0121421F;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lmts_frame.sv
// Frame buffer of active-low row words with a one-column-per-cycle pixel writer.
// Depends on lmts_pkg for the control struct.
`default_nettype none

module lmts_frame
    import lmts_pkg::*;
#(
    parameter int ROWS      = DEF_ROWS,
    parameter int COLUMNS   = DEF_COLUMNS,
    parameter int ROW_BYTES = DEF_ROW_BYTES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_frame_ctl             i_ctl,
    input  logic [SCAN_W-1:0]      i_rd_row,
    output logic [ROW_BYTES*8-1:0] o_rd_word
);

    localparam int WORD_BITS = ROW_BYTES * 8;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic signed [7:0] COL_LIMIT = 8'(COLUMNS);
    localparam logic signed [7:0] TOP_BIT   = 8'(COLUMNS - 1);
    localparam logic signed [7:0] BIT_LIMIT = 8'(WORD_BITS);

    logic [WORD_BITS-1:0] r_frame [ROWS];

    logic signed [7:0] bit_pos;
    logic              col_ok;
    logic [BIT_W-1:0]  bit_idx;
    logic [ROWS-1:0]   row_wen;
    logic [ROWS-1:0]   row_val;

    assign bit_pos = TOP_BIT - i_ctl.col;
    assign col_ok  = !i_ctl.col[7] && (i_ctl.col < COL_LIMIT) && (bit_pos < BIT_LIMIT);
    assign bit_idx = bit_pos[BIT_W-1:0];

    always_comb begin
        logic signed [4:0] yidx;
        for (int r = 0; r < ROWS; r++) begin
            yidx = 5'(6 - r) + {i_ctl.row[3], i_ctl.row};
            row_wen[r] = !yidx[4] && (yidx <= 5'sd6) && i_ctl.mask[yidx[2:0]];
            row_val[r] = !(i_ctl.bits[yidx[2:0]] ^ i_ctl.inv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_frame[r] <= '0;
            end
        end else if (i_ctl.fill_en) begin
            for (int r = 0; r < ROWS; r++) begin
                r_frame[r] <= {WORD_BITS{i_ctl.fill_val}};
            end
        end else if (i_ctl.col_en && col_ok) begin
            for (int r = 0; r < ROWS; r++) begin
                if (row_wen[r]) begin
                    r_frame[r][bit_idx] <= row_val[r];
                end
            end
        end
    end

    assign o_rd_word = r_frame[i_rd_row[ROW_IDX_W-1:0]];

endmodule

`default_nettype wire

FILE: rtl/led_matrix_text_scan_controller.sv
// Top level of the LED matrix text scan controller: command sequencer and result register.
// Depends on lmts_pkg and lmts_frame.
//
// Commands arrive as words on the input channel (i_in_valid / o_in_ready) and
// scan results leave on the output channel (o_out_valid / i_out_ready).
// A scan tick reads the current row at acceptance and shows its row index and
// pattern on the output from the next cycle; each tick advances the row and
// wraps after the last row. Set pixel and draw glyph keep the block busy after
// acceptance; a glyph is drawn one font column per cycle through the shared
// column writer. All off, all lit and unknown codes finish in the accepting
// cycle. Ticks can be taken every cycle while the receiver takes each result.
// The output register holds one result; while it is full and the receiver
// stalls, o_in_ready stays low. Reset lights every LED, restarts the scan at
// row 0 and empties the output register.
`default_nettype none

module led_matrix_text_scan_controller
    import lmts_pkg::*;
#(
    parameter int ROWS      = DEF_ROWS,
    parameter int COLUMNS   = DEF_COLUMNS,
    parameter int ROW_BYTES = DEF_ROW_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic signed [3:0]    i_row_pos,
    input  logic signed [6:0]    i_col_pos,
    input  logic                 i_lit,
    input  logic [7:0]           i_char_code,
    input  logic                 i_inverse_video,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [SCAN_W-1:0]    o_scan_row,
    output logic [PATTERN_W-1:0] o_row_pattern
);

    localparam int WORD_BITS = ROW_BYTES * 8;
    localparam logic [SCAN_W:0] ROW_LIMIT = (SCAN_W + 1)'(ROWS);

    t_state n_state;
    t_state r_state;

    logic [2:0]              r_steps;
    logic signed [7:0]       r_col;
    logic signed [3:0]       r_row;
    logic [39:0]             r_glyph;
    logic [6:0]              r_mask;
    logic                    r_inv;
    logic [SCAN_W-1:0]       r_scan;
    logic                    r_out_valid;
    logic [SCAN_W-1:0]       r_out_row;
    logic [PATTERN_W-1:0]    r_out_pattern;

    logic                    accept;
    logic [SCAN_W-1:0]       scan_idx;
    logic [SCAN_W:0]         scan_inc;
    logic [SCAN_W-1:0]       n_scan;
    logic [WORD_BITS-1:0]    rd_word;
    t_frame_ctl              frame_ctl;

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    assign scan_idx = ({1'b0, r_scan} >= ROW_LIMIT) ? '0 : r_scan;
    assign scan_inc = {1'b0, scan_idx} + 1'b1;
    assign n_scan   = (scan_inc >= ROW_LIMIT) ? '0 : scan_inc[SCAN_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_cmd == CMD_PIXEL || i_cmd == CMD_GLYPH)) begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (r_steps == 3'd1) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        frame_ctl.fill_en  = accept && (i_cmd == CMD_ALL_OFF || i_cmd == CMD_ALL_ON);
        frame_ctl.fill_val = (i_cmd == CMD_ALL_OFF);
        frame_ctl.col_en   = (r_state == ST_DRAW);
        frame_ctl.col      = r_col;
        frame_ctl.row      = r_row;
        frame_ctl.bits     = r_glyph[38:32];
        frame_ctl.mask     = r_mask;
        frame_ctl.inv      = r_inv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && i_cmd == CMD_TICK) begin
                r_scan      <= n_scan;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_cmd == CMD_TICK) begin
            r_out_row     <= scan_idx;
            r_out_pattern <= PATTERN_W'(rd_word);
        end
        if (r_state == ST_IDLE) begin
            r_col <= {i_col_pos[6], i_col_pos};
            r_row <= i_row_pos;
            if (i_cmd == CMD_GLYPH) begin
                r_steps <= GLYPH_STEPS;
                r_glyph <= f_glyph(i_char_code);
                r_mask  <= MASK_GLYPH;
                r_inv   <= i_inverse_video;
            end else begin
                r_steps <= PIXEL_STEPS;
                r_glyph <= {8'h40, 32'h0};
                r_mask  <= MASK_PIXEL;
                r_inv   <= !i_lit;
            end
        end else begin
            r_steps <= r_steps - 3'd1;
            r_col   <= r_col + 8'sd1;
            r_glyph <= {r_glyph[31:0], 8'h00};
        end
    end

    lmts_frame #(
        .ROWS      (ROWS),
        .COLUMNS   (COLUMNS),
        .ROW_BYTES (ROW_BYTES)
    ) u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (frame_ctl),
        .i_rd_row  (scan_idx),
        .o_rd_word (rd_word)
    );

    assign o_out_valid   = r_out_valid;
    assign o_scan_row    = r_out_row;
    assign o_row_pattern = r_out_pattern;

endmodule

`default_nettype wire

FILE: rtl/lmts_checker.sv
// Port-level checker for the LED matrix text scan controller, bound to the top level.
// Depends on lmts_pkg.
`default_nettype none

module lmts_checker
    import lmts_pkg::*;
#(
    parameter int ROWS = DEF_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic [SCAN_W-1:0]    o_scan_row,
    input  logic [PATTERN_W-1:0] o_row_pattern
);

    localparam logic [SCAN_W:0] ROW_LIMIT = (SCAN_W + 1)'(ROWS);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_scan_row) && $stable(o_row_pattern))
        else $error("Stalled result word changed or dropped.");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_scan_row} < ROW_LIMIT))
        else $error("Scan row index out of range.");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd == CMD_TICK |=> o_out_valid)
        else $error("Accepted scan tick gave no result word.");

    a_glyph_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd == CMD_GLYPH |=> !o_in_ready)
        else $error("Input taken while a glyph is being drawn.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result word present after reset.");

endmodule

bind led_matrix_text_scan_controller lmts_checker #(.ROWS(ROWS)) u_lmts_checker (.*);

`default_nettype wire

FILE: dv/led_matrix_text_scan_controller_test.sv
// Testbench for led_matrix_text_scan_controller: drives command words, mirrors the frame
// buffer and row scanner in a local model, and checks every scan word that comes out.
// Depends on lmts_pkg and the led_matrix_text_scan_controller RTL.
`timescale 1ns / 100ps

module led_matrix_text_scan_controller_test;
    import lmts_pkg::*;

    localparam int NUM_ROWS = 7;
    localparam int NUM_COLS = 50;
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_ALL_ON + 3'd1;
    localparam logic [7:0] CODE_ASCII_LO = 8'd32;
    localparam logic [7:0] CODE_ASCII_HI = 8'd126;

    localparam logic [39:0] FONT_COLS [0:108] = '{
        40'h0000000000, 40'h00007D0000, 40'h0070007000, 40'h143E143E14, 40'h102A7F2A04,
        40'h6264081323, 40'h3649552205, 40'h0050600000, 40'h1C22414100, 40'h004141221C,
        40'h2A1CFF1C2A, 40'h08083E0808, 40'h0005060000, 40'h0808080808, 40'h0003030000,
        40'h0204081020, 40'h3E4549513E, 40'h11217F0101, 40'h2143454931, 40'h4241515966,
        40'h0C1424FF04, 40'h725151514E, 40'h3E49494926, 40'h4344485060, 40'h3649494936,
        40'h324949493E, 40'h0036000000, 40'h0035360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h20404D5030, 40'h3E4955493A, 40'h1F2444241F, 40'h7F49494936,
        40'h3E41414120, 40'h7F4141221C, 40'h7F49494941, 40'h7F48484840, 40'h3E4149492E,
        40'h7F0808087F, 40'h4141FF4141, 40'h0641417E40, 40'h7F08142241, 40'h7F01010101,
        40'h7F2010207F, 40'h7F1008047F, 40'h3E4141413E, 40'h7F48484830, 40'h3E4145423D,
        40'h7F48484837, 40'h3249494926, 40'h40407F4040, 40'h7E0101017E, 40'h7C0201027E,
        40'h7E010E017E, 40'h6314081463, 40'h7008070870, 40'h4345495161, 40'h007F414100,
        40'h2010080402, 40'h0041417F00, 40'h1020402010, 40'h0101010101, 40'h0040201000,
        40'h021515150F, 40'h7F1111110E, 40'h0E11111102, 40'h0E1111097F, 40'h0E1515150C,
        40'h00083F4820, 40'h0C1515151E, 40'h7F0810100F, 40'h00115F0100, 40'h0201012E00,
        40'h7F040C1201, 40'h00407F0000, 40'h0F100C100F, 40'h1F0810100F, 40'h0E1111110E,
        40'h3F14242418, 40'h182424283F, 40'h1F08101008, 40'h0915151502, 40'h107E110102,
        40'h1E0101021F, 40'h1C0201021C, 40'h1E0106011E, 40'h110A040A11, 40'h180505051E,
        40'h1113151911, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0408040204,
        40'h1E2151221F, 40'h0E51315102, 40'h4E2949067F, 40'h0E5535550C, 40'h1F4830500F,
        40'h1F48305008, 40'h0955355502, 40'h107E115162, 40'h1153355911, 40'h021535550F,
        40'h0E1535550C, 40'h00092F4100, 40'h0E1131510E, 40'h1E0121421F
    };

    localparam logic [7:0] ACCENT_CODES [0:13] = '{
        8'd249, 8'd232, 8'd239, 8'd236, 8'd242, 8'd248, 8'd154,
        8'd157, 8'd158, 8'd225, 8'd233, 8'd237, 8'd243, 8'd250
    };

    typedef struct {
        logic [SCAN_W-1:0]    row;
        logic [PATTERN_W-1:0] pattern;
    } t_scan_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [CMD_W-1:0]     i_cmd;
    logic signed [3:0]    i_row_pos;
    logic signed [6:0]    i_col_pos;
    logic                 i_lit;
    logic [7:0]           i_char_code;
    logic                 i_inverse_video;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [SCAN_W-1:0]    o_scan_row;
    logic [PATTERN_W-1:0] o_row_pattern;

    logic [PATTERN_W-1:0] frame_model [NUM_ROWS];
    int                   next_scan_row;
    t_scan_word           pending_scans [$];
    int                   error_count;
    int                   tx_idle_pct;
    int                   rx_idle_pct;

    led_matrix_text_scan_controller DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_row_pos       (i_row_pos),
        .i_col_pos       (i_col_pos),
        .i_lit           (i_lit),
        .i_char_code     (i_char_code),
        .i_inverse_video (i_inverse_video),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_scan_row      (o_scan_row),
        .o_row_pattern   (o_row_pattern)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic logic [39:0] glyph_columns(input logic [7:0] code);
        logic [39:0] cols;
        cols = '0;
        if (code >= CODE_ASCII_LO && code <= CODE_ASCII_HI) begin
            cols = FONT_COLS[code - CODE_ASCII_LO];
        end else begin
            for (int i = 0; i < 14; i++) begin
                if (ACCENT_CODES[i] == code) begin
                    cols = FONT_COLS[95 + i];
                end
            end
        end
        return cols;
    endfunction

    function automatic void paint_pixel(input int r, input int c, input bit light);
        if (r >= 0 && r < NUM_ROWS && c >= 0 && c < NUM_COLS) begin
            frame_model[r][NUM_COLS - 1 - c] = ~light;
        end
    endfunction

    function automatic void apply_command_to_frame(
        input logic [CMD_W-1:0] cmd,
        input logic signed [3:0] row_pos,
        input logic signed [6:0] col_pos,
        input logic lit,
        input logic [7:0] code,
        input logic inv
    );
        logic [39:0] cols;
        logic [7:0]  col_bits;
        t_scan_word  word;
        case (cmd)
            CMD_TICK: begin
                if (next_scan_row >= NUM_ROWS) begin
                    next_scan_row = 0;
                end
                word.row     = next_scan_row[SCAN_W-1:0];
                word.pattern = frame_model[next_scan_row];
                pending_scans.push_back(word);
                next_scan_row = (next_scan_row + 1 >= NUM_ROWS) ? 0 : next_scan_row + 1;
            end
            CMD_PIXEL: begin
                paint_pixel(int'(row_pos), int'(col_pos), lit);
            end
            CMD_GLYPH: begin
                cols = glyph_columns(code);
                for (int x = 0; x < 5; x++) begin
                    col_bits = cols[39 - 8 * x -: 8];
                    for (int y = 0; y < 7; y++) begin
                        paint_pixel(int'(row_pos) + y, int'(col_pos) + x,
                                    col_bits[6 - y] != inv);
                    end
                end
            end
            CMD_ALL_OFF: begin
                for (int r = 0; r < NUM_ROWS; r++) frame_model[r] = '1;
            end
            CMD_ALL_ON: begin
                for (int r = 0; r < NUM_ROWS; r++) frame_model[r] = '0;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_scan_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_scans.size() == 0) begin
                report_mismatch("unexpected scan word", 64'({o_scan_row, o_row_pattern}),
                                '0);
            end else begin
                want = pending_scans.pop_front();
                if (o_scan_row !== want.row) begin
                    report_mismatch("scan_row", 64'(o_scan_row), 64'(want.row));
                end
                if (o_row_pattern !== want.pattern) begin
                    report_mismatch("row_pattern", 64'(o_row_pattern), 64'(want.pattern));
                end
            end
        end
    end

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance of the word.
    task automatic send_command(
        input logic [CMD_W-1:0] cmd,
        input logic signed [3:0] row_pos,
        input logic signed [6:0] col_pos,
        input logic lit,
        input logic [7:0] code,
        input logic inv
    );
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_cmd           = cmd;
        i_row_pos       = row_pos;
        i_col_pos       = col_pos;
        i_lit           = lit;
        i_char_code     = code;
        i_inverse_video = inv;
        do @(posedge i_clk); while (!o_in_ready);
        apply_command_to_frame(cmd, row_pos, col_pos, lit, code, inv);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_simple(input logic [CMD_W-1:0] cmd);
        send_command(cmd, 4'sd0, 7'sd0, 1'b0, 8'd0, 1'b0);
    endtask

    task automatic send_pixel(input int r, input int c, input logic lit);
        send_command(CMD_PIXEL, r[3:0], c[6:0], lit, 8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_glyph(input int r, input int c, input logic [7:0] code,
                              input logic inv);
        send_command(CMD_GLYPH, r[3:0], c[6:0], 1'($urandom_range(0, 1)), code, inv);
    endtask

    task automatic scan_whole_frame();
        repeat (NUM_ROWS) send_simple(CMD_TICK);
    endtask

    task automatic wait_for_drain();
        while (pending_scans.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_scan_after_reset();
        scan_whole_frame();
    endtask

    task automatic test_pixels_and_fills();
        send_simple(CMD_ALL_OFF);
        send_simple(CMD_FIRST_UNUSED);
        send_simple(CMD_FIRST_UNUSED + 3'd2);
        send_pixel(0, 0, 1'b1);
        send_pixel(6, 49, 1'b1);
        send_pixel(-8, 10, 1'b1);
        send_pixel(3, 50, 1'b1);
        send_pixel(3, -1, 1'b1);
        send_pixel(3, 63, 1'b1);
        send_pixel(0, 0, 1'b0);
        scan_whole_frame();
        send_simple(CMD_ALL_ON);
        send_simple(CMD_TICK);
    endtask

    task automatic test_glyphs();
        send_simple(CMD_ALL_OFF);
        send_glyph(0, 2, 8'd65, 1'b0);
        send_glyph(0, 10, 8'd250, 1'b1);
        send_glyph(0, 20, 8'd0, 1'b1);
        send_glyph(-3, 30, 8'd255, 1'b0);
        send_glyph(4, 47, 8'd87, 1'b0);
        send_glyph(1, -2, 8'd42, 1'b1);
        scan_whole_frame();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int          pick;
        logic [7:0]  code;
        logic [6:0]  col;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            code = ($urandom_range(0, 9) < 4) ? 8'($urandom_range(32, 126)) :
                   ($urandom_range(0, 1) == 0) ? ACCENT_CODES[$urandom_range(0, 13)] :
                   8'($urandom_range(0, 255));
            col  = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) :
                   7'($signed($urandom_range(0, 63)) - 8);
            if (pick < 38) begin
                send_command(CMD_TICK, 4'($urandom), col, 1'($urandom), code, 1'($urandom));
            end else if (pick < 60) begin
                send_command(CMD_PIXEL, 4'($urandom), col, 1'($urandom), code,
                             1'($urandom));
            end else if (pick < 88) begin
                send_command(CMD_GLYPH, 4'($urandom), col, 1'($urandom), code,
                             1'($urandom));
            end else if (pick < 92) begin
                send_command(CMD_ALL_OFF, 4'($urandom), col, 1'($urandom), code,
                             1'($urandom));
            end else if (pick < 96) begin
                send_command(CMD_ALL_ON, 4'($urandom), col, 1'($urandom), code,
                             1'($urandom));
            end else begin
                send_command(CMD_FIRST_UNUSED + 3'($urandom_range(0, 2)), 4'($urandom),
                             col, 1'($urandom), code, 1'($urandom));
            end
        end
        wait_for_drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_cmd           = CMD_TICK;
        i_row_pos       = '0;
        i_col_pos       = '0;
        i_lit           = 1'b0;
        i_char_code     = '0;
        i_inverse_video = 1'b0;
        error_count     = 0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        next_scan_row   = 0;
        for (int r = 0; r < NUM_ROWS; r++) frame_model[r] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_scan_after_reset();
        test_pixels_and_fills();
        test_glyphs();
        wait_for_drain();
        test_random_traffic(20, 74, 285);
        test_random_traffic(74, 20, 285);
        test_random_traffic(0, 0, 285);

        repeat (10) @(posedge i_clk);
        if (pending_scans.size() != 0) begin
            report_mismatch("scan words never delivered", 64'(pending_scans.size()), '0);
        end
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
